// ===== sv/trm_pkg.sv =====
`default_nettype none

package trm_pkg;

   localparam int GLYPH_COUNT_DEFAULT = 128;
   localparam int ROW_BITS_DEFAULT    = 4;

   localparam int CHARS_PER_WORD = 4;
   localparam int CHAR_W         = 8;
   localparam int WORD_W         = CHARS_PER_WORD * CHAR_W;
   localparam int FONT_ADDR_W    = 11;
   localparam int ROW_IN_W       = 4;
   localparam int POS_W          = 9;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam logic KIND_FONT = 1'b0;
   localparam logic KIND_WORD = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_CHAR     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORDS_PER_LINE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GFX_START_WORD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GFX_LEN_WORDS  = 3'd3;

   localparam logic [7:0]       FIRST_CHAR_RESET     = 8'd32;
   localparam logic [POS_W-1:0] WORDS_PER_LINE_RESET = 9'd20;

   typedef struct packed {
      logic                      valid;
      logic [CHARS_PER_WORD-1:0] blank;
      logic [WORD_W-1:0]         gfx_bits;
      logic                      overlay;
      logic                      eol;
   } stage_type;

   typedef struct packed {
      logic [WORD_W-1:0] pixel_word;
      logic              overlay_applied;
      logic              end_of_line;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/trm_ram.sv =====
`default_nettype none

module trm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/trm_front.sv =====
`default_nettype none

module trm_front #(
   parameter int GLYPH_COUNT = trm_pkg::GLYPH_COUNT_DEFAULT,
   parameter int ROW_BITS    = trm_pkg::ROW_BITS_DEFAULT,
   parameter int FONT_AW     = trm_pkg::FONT_ADDR_W
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   output logic                                      full,
   input  wire logic                                 req_kind,
   input  wire logic [trm_pkg::FONT_ADDR_W-1:0]      req_font_addr,
   input  wire logic [trm_pkg::CHAR_W-1:0]           req_font_byte,
   input  wire logic [trm_pkg::CHAR_W-1:0]           req_char0,
   input  wire logic [trm_pkg::CHAR_W-1:0]           req_char1,
   input  wire logic [trm_pkg::CHAR_W-1:0]           req_char2,
   input  wire logic [trm_pkg::CHAR_W-1:0]           req_char3,
   input  wire logic [trm_pkg::ROW_IN_W-1:0]         req_glyph_row,
   input  wire logic                                 req_gfx_line,
   input  wire logic [trm_pkg::WORD_W-1:0]           req_gfx_word,
   input  wire logic                                 valid,
   output logic                                      ready,
   input  wire logic [trm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [trm_pkg::CSR_DATA_W-1:0]       csr_data,
   input  wire logic                                 room,
   output logic                                      font_wr_en,
   output logic [FONT_AW-1:0]                        font_wr_addr,
   output logic [trm_pkg::CHAR_W-1:0]                font_wr_data,
   output logic                                      font_rd_en,
   output logic [trm_pkg::CHARS_PER_WORD-1:0][FONT_AW-1:0] font_rd_addr,
   output trm_pkg::stage_type                        stage
);

   localparam int GLYPH_AW   = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int FONT_DEPTH = GLYPH_COUNT << ROW_BITS;
   localparam int DEPTH_W    = 14;

   logic [7:0]                    first_char_ff;
   logic [trm_pkg::POS_W-1:0]     wpl_ff;
   logic [7:0]                    gfx_start_ff;
   logic [trm_pkg::POS_W-1:0]     gfx_len_ff;
   logic [trm_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [trm_pkg::POS_W-1:0]     remain_ff, remain_in;
   trm_pkg::stage_type            stage_ff, stage_in;

   logic                          accept, word_item;
   logic [trm_pkg::POS_W-1:0]     remain_cur, wpl_eff;
   logic                          overlay, eol;
   logic [ROW_BITS-1:0]           row_sel;
   logic [trm_pkg::CHAR_W-1:0]    code [trm_pkg::CHARS_PER_WORD];
   logic [trm_pkg::CHAR_W-1:0]    idx  [trm_pkg::CHARS_PER_WORD];
   logic [trm_pkg::CHARS_PER_WORD-1:0] blank;

   assign full      = !room;
   assign ready     = 1'b1;
   assign accept    = push && !full;
   assign word_item = accept && (req_kind == trm_pkg::KIND_WORD);

   assign code[0] = req_char0;
   assign code[1] = req_char1;
   assign code[2] = req_char2;
   assign code[3] = req_char3;
   assign row_sel = ROW_BITS'(req_glyph_row);

   always_comb begin
      for (int i = 0; i < trm_pkg::CHARS_PER_WORD; i++) begin
         idx[i]          = code[i] - first_char_ff;
         blank[i]        = !({1'b0, idx[i]} < 9'(GLYPH_COUNT));
         font_rd_addr[i] = {idx[i][GLYPH_AW-1:0], row_sel};
      end
   end

   assign font_rd_en   = word_item;
   assign font_wr_en   = accept && (req_kind == trm_pkg::KIND_FONT) &&
                         ({3'b000, req_font_addr} < DEPTH_W'(FONT_DEPTH));
   assign font_wr_addr = FONT_AW'(req_font_addr);
   assign font_wr_data = req_font_byte;

   always_comb begin
      remain_cur = remain_ff;
      if (pos_ff == '0) begin
         remain_cur = req_gfx_line ? gfx_len_ff : '0;
      end
      overlay   = (pos_ff >= {1'b0, gfx_start_ff}) && (remain_cur != '0);
      remain_in = overlay ? remain_cur - 9'd1 : remain_cur;
      wpl_eff   = (wpl_ff == '0) ? 9'd1 : wpl_ff;
      eol       = pos_ff >= (wpl_eff - 9'd1);
      pos_in    = eol ? '0 : pos_ff + 9'd1;

      stage_in.valid    = word_item;
      stage_in.blank    = blank;
      stage_in.gfx_bits = overlay ? req_gfx_word : '0;
      stage_in.overlay  = overlay;
      stage_in.eol      = eol;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_char_ff <= trm_pkg::FIRST_CHAR_RESET;
         wpl_ff        <= trm_pkg::WORDS_PER_LINE_RESET;
         gfx_start_ff  <= '0;
         gfx_len_ff    <= '0;
      end else if (valid) begin
         unique case (csr_index)
            trm_pkg::CSR_FIRST_CHAR:     first_char_ff <= csr_data[7:0];
            trm_pkg::CSR_WORDS_PER_LINE: wpl_ff        <= csr_data;
            trm_pkg::CSR_GFX_START_WORD: gfx_start_ff  <= csr_data[7:0];
            trm_pkg::CSR_GFX_LEN_WORDS:  gfx_len_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         remain_ff      <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         if (word_item) begin
            pos_ff    <= pos_in;
            remain_ff <= remain_in;
         end
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.blank    <= stage_in.blank;
      stage_ff.gfx_bits <= stage_in.gfx_bits;
      stage_ff.overlay  <= stage_in.overlay;
      stage_ff.eol      <= stage_in.eol;
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

// ===== sv/trm_back.sv =====
`default_nettype none

module trm_back (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire trm_pkg::stage_type                          stage,
   input  wire logic [trm_pkg::CHARS_PER_WORD-1:0][trm_pkg::CHAR_W-1:0] glyph_data,
   output logic                                             room,
   output logic                                             empty,
   input  wire logic                                        pop,
   output logic [trm_pkg::WORD_W-1:0]                       rsp_pixel_word,
   output logic                                             rsp_overlay_applied,
   output logic                                             rsp_end_of_line
);

   trm_pkg::result_type               queue_ff [trm_pkg::QUEUE_DEPTH];
   logic [trm_pkg::QPTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [trm_pkg::QCNT_W-1:0]        count_ff, count_in;
   trm_pkg::result_type               result;
   logic                              do_pop;
   logic [trm_pkg::QCNT_W:0]          pending;

   always_comb begin
      for (int i = 0; i < trm_pkg::CHARS_PER_WORD; i++) begin
         result.pixel_word[i*trm_pkg::CHAR_W +: trm_pkg::CHAR_W] =
            stage.blank[i] ? '0 : glyph_data[i];
      end
      result.pixel_word      = result.pixel_word | stage.gfx_bits;
      result.overlay_applied = stage.overlay;
      result.end_of_line     = stage.eol;
   end

   assign empty  = (count_ff == '0);
   assign do_pop = pop && !empty;

   // one slot held back for the word in the read stage
   assign pending = {1'b0, count_ff} + {{trm_pkg::QCNT_W{1'b0}}, stage.valid};
   assign room    = pending < (trm_pkg::QCNT_W + 1)'(trm_pkg::QUEUE_DEPTH);

   always_comb begin
      count_in = count_ff;
      if (stage.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!stage.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (stage.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
      if (stage.valid) begin
         queue_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_pixel_word      = queue_ff[rd_ptr_ff].pixel_word;
   assign rsp_overlay_applied = queue_ff[rd_ptr_ff].overlay_applied;
   assign rsp_end_of_line     = queue_ff[rd_ptr_ff].end_of_line;

endmodule

`default_nettype wire

// ===== sv/text_mode_raster_word_generator_unit.sv =====
`default_nettype none

// channel | handshake                  | payload
// --------+----------------------------+---------------------------------------------
// req     | push / full                | kind, font_addr, font_byte, char0..3,
//         |                            | glyph_row, gfx_line, gfx_word
// rsp     | empty / pop                | pixel_word, overlay_applied, end_of_line
// csr     | valid / ready              | index, data
//
// One word a cycle sustained while full stays low; a pixel word can be popped once
// its font read and its write into the output queue are done.
// Latency comes from the registered font read (four replicated font RAMs, one per char)
// and the write into the output queue.
// Font writes give no word.
// Four-entry output queue; full rises when it cannot absorb the word in flight.
// Synchronous reset clears counters and empties the queue; font contents are not cleared.

module text_mode_raster_word_generator_unit #(
   parameter int GLYPH_COUNT = trm_pkg::GLYPH_COUNT_DEFAULT,
   parameter int ROW_BITS    = trm_pkg::ROW_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   output logic                                   full,
   input  wire logic                              req_kind,
   input  wire logic [trm_pkg::FONT_ADDR_W-1:0]   req_font_addr,
   input  wire logic [trm_pkg::CHAR_W-1:0]        req_font_byte,
   input  wire logic [trm_pkg::CHAR_W-1:0]        req_char0,
   input  wire logic [trm_pkg::CHAR_W-1:0]        req_char1,
   input  wire logic [trm_pkg::CHAR_W-1:0]        req_char2,
   input  wire logic [trm_pkg::CHAR_W-1:0]        req_char3,
   input  wire logic [trm_pkg::ROW_IN_W-1:0]      req_glyph_row,
   input  wire logic                              req_gfx_line,
   input  wire logic [trm_pkg::WORD_W-1:0]        req_gfx_word,
   output logic                                   empty,
   input  wire logic                              pop,
   output logic [trm_pkg::WORD_W-1:0]             rsp_pixel_word,
   output logic                                   rsp_overlay_applied,
   output logic                                   rsp_end_of_line,
   input  wire logic                              valid,
   output logic                                   ready,
   input  wire logic [trm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [trm_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int GLYPH_AW   = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int FONT_AW    = GLYPH_AW + ROW_BITS;
   localparam int FONT_DEPTH = 1 << FONT_AW;

   logic                                                 room;
   logic                                                 font_wr_en;
   logic [FONT_AW-1:0]                                   font_wr_addr;
   logic [trm_pkg::CHAR_W-1:0]                           font_wr_data;
   logic                                                 font_rd_en;
   logic [trm_pkg::CHARS_PER_WORD-1:0][FONT_AW-1:0]      font_rd_addr;
   logic [trm_pkg::CHARS_PER_WORD-1:0][trm_pkg::CHAR_W-1:0] glyph_data;
   trm_pkg::stage_type                                   stage;

   trm_front #(
      .GLYPH_COUNT (GLYPH_COUNT),
      .ROW_BITS    (ROW_BITS),
      .FONT_AW     (FONT_AW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_kind      (req_kind),
      .req_font_addr (req_font_addr),
      .req_font_byte (req_font_byte),
      .req_char0     (req_char0),
      .req_char1     (req_char1),
      .req_char2     (req_char2),
      .req_char3     (req_char3),
      .req_glyph_row (req_glyph_row),
      .req_gfx_line  (req_gfx_line),
      .req_gfx_word  (req_gfx_word),
      .valid         (valid),
      .ready         (ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .room          (room),
      .font_wr_en    (font_wr_en),
      .font_wr_addr  (font_wr_addr),
      .font_wr_data  (font_wr_data),
      .font_rd_en    (font_rd_en),
      .font_rd_addr  (font_rd_addr),
      .stage         (stage)
   );

   for (genvar g = 0; g < trm_pkg::CHARS_PER_WORD; g++) begin : g_font
      trm_ram #(
         .WIDTH (trm_pkg::CHAR_W),
         .DEPTH (FONT_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (font_wr_en),
         .wr_addr (font_wr_addr),
         .wr_data (font_wr_data),
         .rd_en   (font_rd_en),
         .rd_addr (font_rd_addr[g]),
         .rd_data (glyph_data[g])
      );
   end

   trm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .stage               (stage),
      .glyph_data          (glyph_data),
      .room                (room),
      .empty               (empty),
      .pop                 (pop),
      .rsp_pixel_word      (rsp_pixel_word),
      .rsp_overlay_applied (rsp_overlay_applied),
      .rsp_end_of_line     (rsp_end_of_line)
   );

endmodule

`default_nettype wire
